@@ hw/rtl/ubd_pkg.sv @@
package ubd_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CODE_W = 21;

    // Depth of the code point queue between decoder and byte mapper
    localparam int UBD_QUEUE_DEPTH = 2;

    // Lead byte class limits
    localparam logic [BYTE_W-1:0] LEAD_MULTI_MIN = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD3_MIN      = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD4_MIN      = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD_BAD_MIN   = 8'hf8;

    // Byte map ranges (printable code points that map to themselves)
    localparam logic [CODE_W-1:0] PRINT_A_LO = 21'h21;  // '!'
    localparam logic [CODE_W-1:0] PRINT_A_HI = 21'h7e;  // '~'
    localparam logic [CODE_W-1:0] PRINT_B_LO = 21'ha1;  // inverted exclamation
    localparam logic [CODE_W-1:0] PRINT_B_HI = 21'hac;  // not sign
    localparam logic [CODE_W-1:0] PRINT_C_LO = 21'hae;  // registered sign
    localparam logic [CODE_W-1:0] PRINT_C_HI = 21'hff;  // y with diaeresis

    // Shifted range for the non-printable bytes
    localparam logic [CODE_W-1:0] SHIFT_LO = 21'd256;
    localparam logic [CODE_W-1:0] SHIFT_HI = 21'd323;

    typedef logic [CODE_W-1:0] code_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              token_end;
    } ubd_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              unknown_code;
    } ubd_out_t;

    // Push side of the code point queue
    typedef struct packed {
        logic  valid;
        code_t code;
    } ubd_push_t;

    // Map a code point back to its raw byte
    function automatic ubd_out_t map_code(code_t code);
        ubd_out_t   r;
        logic [6:0] n;
        r = '0;
        n = code[6:0];
        if ((code >= PRINT_A_LO && code <= PRINT_A_HI) ||
            (code >= PRINT_B_LO && code <= PRINT_B_HI) ||
            (code >= PRINT_C_LO && code <= PRINT_C_HI)) begin
            r.out_byte = code[BYTE_W-1:0];
        end else if (code >= SHIFT_LO && code <= SHIFT_HI) begin
            // low seven bits give the index into the 68 shifted bytes
            if (n < 7'd33) begin
                r.out_byte = {1'b0, n};
            end else if (n < 7'd67) begin
                r.out_byte = {1'b0, n} + 8'h5e;
            end else begin
                r.out_byte = 8'had;
            end
        end else begin
            r.unknown_code = 1'b1;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/utf8_byte_level_detokenizer.sv @@
// Channel  Direction  Handshake             Payload
// tok      receive    tok_valid/tok_stall   tok_item  (in_byte, token_end)
// raw      send       raw_valid/raw_stall   raw_item  (out_byte, unknown_code)
//
// One byte is taken per cycle while tok_stall is low; a completed code point passes
// through a queue entry, then the mapper's output register.
// The decoder stalls only when the code point queue is full, which happens
// only after the raw side has held raw_stall.
// Reset clears the decode state, the queue and the output valid.
module utf8_byte_level_detokenizer
    import ubd_pkg::*;
#(
    parameter int QUEUE_DEPTH = UBD_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     tok_valid,
    output logic     tok_stall,
    input  ubd_in_t  tok_item,
    output logic     raw_valid,
    input  logic     raw_stall,
    output ubd_out_t raw_item
);

    ubd_push_t push;
    logic      queue_ready;
    logic      head_valid;
    code_t     head_code;
    logic      pop;

    // Decode UTF-8 bytes into code points
    ubd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_valid   (tok_valid),
        .tok_stall   (tok_stall),
        .tok_item    (tok_item),
        .queue_ready (queue_ready),
        .push        (push)
    );

    // Buffer code points between the two halves
    ubd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .ready      (queue_ready),
        .head_valid (head_valid),
        .head_code  (head_code),
        .pop        (pop)
    );

    // Map code points back to raw bytes
    ubd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_code  (head_code),
        .pop        (pop),
        .raw_valid  (raw_valid),
        .raw_stall  (raw_stall),
        .raw_item   (raw_item)
    );

endmodule

@@ hw/rtl/ubd_front.sv @@
module ubd_front
    import ubd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tok_valid,
    output logic      tok_stall,
    input  ubd_in_t   tok_item,
    input  logic      queue_ready,
    output ubd_push_t push
);

    logic [1:0]        pending_reg, pending_next;
    code_t             accum_reg, accum_next;
    logic              drop_reg, drop_next;
    logic              accept;
    logic [BYTE_W-1:0] b;
    code_t             cont;

    assign tok_stall = !queue_ready;
    assign accept    = tok_valid && queue_ready;
    assign b         = tok_item.in_byte;
    assign cont      = {accum_reg[CODE_W-7:0], b[5:0]};

    // Decode the lead or continuation byte of each transfer
    always_comb
    begin
        pending_next = pending_reg;
        accum_next   = accum_reg;
        drop_next    = drop_reg;
        push.valid   = 1'b0;
        push.code    = cont;
        if (accept)
        begin
            if (drop_reg)
            begin
                // ignore the rest of the token
            end
            else if (pending_reg == 2'd0)
            begin
                if (b < LEAD_MULTI_MIN)
                begin
                    push.valid = 1'b1;
                    push.code  = {{(CODE_W-BYTE_W){1'b0}}, b};
                end
                else if (b < LEAD3_MIN)
                begin
                    accum_next   = {{(CODE_W-5){1'b0}}, b[4:0]};
                    pending_next = 2'd1;
                end
                else if (b < LEAD4_MIN)
                begin
                    accum_next   = {{(CODE_W-4){1'b0}}, b[3:0]};
                    pending_next = 2'd2;
                end
                else if (b < LEAD_BAD_MIN)
                begin
                    accum_next   = {{(CODE_W-3){1'b0}}, b[2:0]};
                    pending_next = 2'd3;
                end
                else
                begin
                    drop_next = 1'b1;
                end
            end
            else
            begin
                pending_next = pending_reg - 2'd1;
                if (pending_reg == 2'd1)
                begin
                    push.valid = 1'b1;
                    accum_next = '0;
                end
                else
                begin
                    accum_next = cont;
                end
            end
            // clear at the end of a token, dropping any partial sequence
            if (tok_item.token_end)
            begin
                pending_next = 2'd0;
                accum_next   = '0;
                drop_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            accum_reg   <= '0;
            drop_reg    <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            accum_reg   <= accum_next;
            drop_reg    <= drop_next;
        end
    end

endmodule

@@ hw/rtl/ubd_queue.sv @@
module ubd_queue
    import ubd_pkg::*;
#(
    parameter int DEPTH = UBD_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ubd_push_t push,
    output logic      ready,
    output logic      head_valid,
    output code_t     head_code,
    input  logic      pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    code_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign ready      = count_reg != CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_code  = mem[rd_ptr_reg];
    assign do_push    = push.valid && ready;
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap and track fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.code;
        end
    end

endmodule

@@ hw/rtl/ubd_back.sv @@
module ubd_back
    import ubd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  code_t    head_code,
    output logic     pop,
    output logic     raw_valid,
    input  logic     raw_stall,
    output ubd_out_t raw_item
);

    logic     out_valid_reg, out_valid_next;
    ubd_out_t out_item_reg;

    // Load the output register when it is empty or being drained
    assign pop            = head_valid && (!out_valid_reg || !raw_stall);
    assign out_valid_next = pop ? 1'b1 : (out_valid_reg && raw_stall);
    assign raw_valid      = out_valid_reg;
    assign raw_item       = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Map the code point into the payload register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= map_code(head_code);
        end
    end

endmodule
